@@ rtl/woi_pkg.sv @@
// Shared types, constants and tables for the wheel odometry integrator.
// No dependencies; used by woi_ctrl, woi_dpath, the top level and the bench.
package woi_pkg;

    localparam int CFG_W            = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int IDX_W            = 5;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TPM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP = 2'd1;

    localparam logic [CFG_W-1:0] TPM_RESET = 24'd262236;
    localparam logic [CFG_W-1:0] SEP_RESET = 24'd164000;

    localparam logic [31:0] GAIN_Q30  = 32'd652032874;
    localparam logic [31:0] RAD_TO_BA = 32'd2670177;
    localparam logic [31:0] MEGA      = 32'd1000000;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_CAPT       = 4'd1,
        OP_LOAD_DIST  = 4'd2,
        OP_LOAD_M     = 4'd3,
        OP_LOAD_THETA = 4'd4,
        OP_MUL_LO     = 4'd5,
        OP_MUL_HI     = 4'd6,
        OP_STEP       = 4'd7,
        OP_CINIT      = 4'd8,
        OP_CORDIC     = 4'd9,
        OP_ACCUM      = 4'd10,
        OP_LOAD_LIN   = 4'd11,
        OP_LOAD_TURN  = 4'd12,
        OP_ZERO_VEL   = 4'd13,
        OP_FINISH     = 4'd14
    } op_t;

    typedef enum logic [2:0] {
        MS_M    = 3'd0,
        MS_STEP = 3'd1,
        MS_GAIN = 3'd2,
        MS_LIN  = 3'd3,
        MS_TURN = 3'd4
    } mul_src_t;

    typedef enum logic [1:0] {
        DV_DIST  = 2'd0,
        DV_M     = 2'd1,
        DV_THETA = 2'd2,
        DV_SPEED = 2'd3
    } div_src_t;

    typedef struct packed {
        op_t              op;
        mul_src_t         msrc;
        div_src_t         dsrc;
        logic             div_start;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic time_zero;
        logic out_free;
    } stat_t;

    function automatic logic [31:0] atan_ba(input logic [IDX_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // saturate a sign and magnitude pair to a signed 32-bit word
    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        if (!neg)
        begin
            r = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
        else
        begin
            r = (mag >= 64'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
        end
        return r;
    endfunction

endpackage

@@ rtl/woi_div.sv @@
// Unsigned 64 by 32 restoring divider, two quotient bits per cycle.
// Depends on nothing beyond its ports.
module woi_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic [63:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] r1, r2;
    logic        ge1, ge2;
    logic [31:0] rem1;
    logic [63:0] q1;

    always_comb
    begin
        r1       = {rem_reg, q_reg[63]};
        ge1      = (r1 >= {1'b0, d_reg});
        rem1     = ge1 ? 32'(r1 - {1'b0, d_reg}) : r1[31:0];
        q1       = {q_reg[62:0], ge1};
        r2       = {rem1, q1[63]};
        ge2      = (r2 >= {1'b0, d_reg});
        rem_next = ge2 ? 32'(r2 - {1'b0, d_reg}) : r2[31:0];
        q_next   = {q1[62:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ rtl/woi_ctrl.sv @@
// Sequencing state machine for the odometry integrator.
// Depends on woi_pkg; drives woi_dpath through command and status structs.
module woi_ctrl
#(
    parameter int CORDIC_STEPS = woi_pkg::CORDIC_STEPS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  woi_pkg::stat_t stat,
    output woi_pkg::cmd_t  cmd
);

    typedef enum logic [21:0] {
        S_IDLE    = 22'd1 << 0,
        S_DIVD    = 22'd1 << 1,
        S_DIVM    = 22'd1 << 2,
        S_MULM_LO = 22'd1 << 3,
        S_MULM_HI = 22'd1 << 4,
        S_DIVT    = 22'd1 << 5,
        S_MULS_LO = 22'd1 << 6,
        S_MULS_HI = 22'd1 << 7,
        S_STEP    = 22'd1 << 8,
        S_MULG_LO = 22'd1 << 9,
        S_MULG_HI = 22'd1 << 10,
        S_CINIT   = 22'd1 << 11,
        S_CORD    = 22'd1 << 12,
        S_ACCUM   = 22'd1 << 13,
        S_ZVEL    = 22'd1 << 14,
        S_MULL_LO = 22'd1 << 15,
        S_MULL_HI = 22'd1 << 16,
        S_DIVL    = 22'd1 << 17,
        S_MULR_LO = 22'd1 << 18,
        S_MULR_HI = 22'd1 << 19,
        S_DIVR    = 22'd1 << 20,
        S_FIN     = 22'd1 << 21
    } state_t;

    localparam logic [woi_pkg::IDX_W-1:0] LAST_IDX = woi_pkg::IDX_W'(CORDIC_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [woi_pkg::IDX_W-1:0]   cnt_reg, cnt_next;
    logic                        div_run_reg, div_run_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        div_run_next  = div_run_reg;
        cmd.op        = woi_pkg::OP_NONE;
        cmd.msrc      = woi_pkg::MS_M;
        cmd.dsrc      = woi_pkg::DV_DIST;
        cmd.div_start = 1'b0;
        cmd.idx       = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = woi_pkg::OP_CAPT;
                    state_next = S_DIVD;
                end
            end
            S_DIVD, S_DIVM, S_DIVT, S_DIVL, S_DIVR:
            begin
                case (state_reg)
                    S_DIVD:  cmd.dsrc = woi_pkg::DV_DIST;
                    S_DIVM:  cmd.dsrc = woi_pkg::DV_M;
                    S_DIVT:  cmd.dsrc = woi_pkg::DV_THETA;
                    default: cmd.dsrc = woi_pkg::DV_SPEED;
                endcase
                if (!div_run_reg)
                begin
                    cmd.div_start = 1'b1;
                    div_run_next  = 1'b1;
                end
                else if (stat.div_done)
                begin
                    div_run_next = 1'b0;
                    case (state_reg)
                        S_DIVD:
                        begin
                            cmd.op     = woi_pkg::OP_LOAD_DIST;
                            state_next = S_DIVM;
                        end
                        S_DIVM:
                        begin
                            cmd.op     = woi_pkg::OP_LOAD_M;
                            state_next = S_MULM_LO;
                        end
                        S_DIVT:
                        begin
                            cmd.op     = woi_pkg::OP_LOAD_THETA;
                            state_next = S_MULS_LO;
                        end
                        S_DIVL:
                        begin
                            cmd.op     = woi_pkg::OP_LOAD_LIN;
                            state_next = S_MULR_LO;
                        end
                        default:
                        begin
                            cmd.op     = woi_pkg::OP_LOAD_TURN;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MULM_LO:
            begin
                cmd.op     = woi_pkg::OP_MUL_LO;
                cmd.msrc   = woi_pkg::MS_M;
                state_next = S_MULM_HI;
            end
            S_MULM_HI:
            begin
                cmd.op     = woi_pkg::OP_MUL_HI;
                cmd.msrc   = woi_pkg::MS_M;
                state_next = S_DIVT;
            end
            S_MULS_LO:
            begin
                cmd.op     = woi_pkg::OP_MUL_LO;
                cmd.msrc   = woi_pkg::MS_STEP;
                state_next = S_MULS_HI;
            end
            S_MULS_HI:
            begin
                cmd.op     = woi_pkg::OP_MUL_HI;
                cmd.msrc   = woi_pkg::MS_STEP;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = woi_pkg::OP_STEP;
                state_next = S_MULG_LO;
            end
            S_MULG_LO:
            begin
                cmd.op     = woi_pkg::OP_MUL_LO;
                cmd.msrc   = woi_pkg::MS_GAIN;
                state_next = S_MULG_HI;
            end
            S_MULG_HI:
            begin
                cmd.op     = woi_pkg::OP_MUL_HI;
                cmd.msrc   = woi_pkg::MS_GAIN;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.op     = woi_pkg::OP_CINIT;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op = woi_pkg::OP_CORDIC;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_ACCUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ACCUM:
            begin
                cmd.op     = woi_pkg::OP_ACCUM;
                state_next = stat.time_zero ? S_ZVEL : S_MULL_LO;
            end
            S_ZVEL:
            begin
                cmd.op     = woi_pkg::OP_ZERO_VEL;
                state_next = S_FIN;
            end
            S_MULL_LO:
            begin
                cmd.op     = woi_pkg::OP_MUL_LO;
                cmd.msrc   = woi_pkg::MS_LIN;
                state_next = S_MULL_HI;
            end
            S_MULL_HI:
            begin
                cmd.op     = woi_pkg::OP_MUL_HI;
                cmd.msrc   = woi_pkg::MS_LIN;
                state_next = S_DIVL;
            end
            S_MULR_LO:
            begin
                cmd.op     = woi_pkg::OP_MUL_LO;
                cmd.msrc   = woi_pkg::MS_TURN;
                state_next = S_MULR_HI;
            end
            S_MULR_HI:
            begin
                cmd.op     = woi_pkg::OP_MUL_HI;
                cmd.msrc   = woi_pkg::MS_TURN;
                state_next = S_DIVR;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = woi_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next   = S_IDLE;
                div_run_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            div_run_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            div_run_reg <= div_run_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

@@ rtl/woi_dpath.sv @@
// Datapath: config, pose state, shared multiplier, divider and CORDIC registers.
// Depends on woi_pkg and woi_div; driven by commands from woi_ctrl.
module woi_dpath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  woi_pkg::cmd_t                  cmd,
    output woi_pkg::stat_t                 stat,
    input  logic                           cfg_we,
    input  logic [woi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [woi_pkg::CFG_W-1:0]      cfg_data,
    input  logic signed [31:0]             left_count,
    input  logic signed [31:0]             right_count,
    input  logic [23:0]                    elapsed_us,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             pose_x,
    output logic signed [31:0]             pose_y,
    output logic [15:0]                    heading,
    output logic signed [31:0]             linear_speed,
    output logic signed [31:0]             turn_rate,
    output logic                           time_zero
);

    localparam logic signed [60:0] ACC_MAX = 61'sd140737488355327;
    localparam logic signed [60:0] ACC_MIN = -61'sd140737488355328;

    function automatic logic [31:0] sat_pose(input logic signed [47:0] v);
        logic signed [47:0] s;
        logic [31:0]        r;
        s = v >>> 8;
        if (s > 48'sh7FFFFFFF)
        begin
            r = 32'h7FFFFFFF;
        end
        else if (s < -48'sh80000000)
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    logic [23:0]        tpm_reg, sep_reg;
    logic [31:0]        prev_left_reg, prev_right_reg;
    logic signed [47:0] acc_x_reg, acc_y_reg;
    logic [31:0]        acc_heading_reg;
    logic               sum_neg_reg, diff_neg_reg;
    logic [32:0]        sum_mag_reg, diff_mag_reg;
    logic [23:0]        el_reg;
    logic               dist_neg_reg, m_neg_reg, theta_neg_reg;
    logic [55:0]        dist_mag_reg;
    logic [43:0]        m_mag_reg;
    logic [40:0]        theta_mag_reg;
    logic [63:0]        prod_lo_reg, prod_hi_reg;
    logic [31:0]        step_reg;
    logic signed [59:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [31:0]        lin_reg, turn_reg;
    logic [31:0]        pose_x_reg, pose_y_reg, lin_out_reg, turn_out_reg;
    logic [15:0]        heading_reg;
    logic               time_zero_reg;
    logic               out_valid_reg;

    logic [31:0]        lu, ru;
    logic [31:0]        dl, dr;
    logic [32:0]        sum33, diff33;
    logic [23:0]        tpm_eff, sep_eff;
    logic [63:0]        dividend;
    logic [31:0]        divisor;
    logic [63:0]        div_q;
    logic               div_done;
    logic [43:0]        dc_mag;
    logic [63:0]        theta_s64;
    logic [63:0]        mul_a64;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic [63:0]        combine;
    logic [47:0]        step_sum;
    logic [63:0]        gain_r;
    logic signed [59:0] x_init, x_fold;
    logic [31:0]        ang, ang_t, ang_f;
    logic signed [59:0] xs, ys;
    logic [33:0]        atan_z;
    logic signed [60:0] sum_x, sum_y;
    logic signed [47:0] acc_x_next, acc_y_next;
    logic               gain_sel;

    woi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        lu     = left_count;
        ru     = 32'd0 - right_count;
        dl     = lu - prev_left_reg;
        dr     = ru - prev_right_reg;
        sum33  = {dl[31], dl} + {dr[31], dr};
        diff33 = {dr[31], dr} - {dl[31], dl};

        tpm_eff = (tpm_reg == 24'd0) ? 24'd1 : tpm_reg;
        sep_eff = (sep_reg == 24'd0) ? 24'd1 : sep_reg;

        combine = prod_lo_reg + {prod_hi_reg[31:0], 32'd0};

        case (cmd.dsrc)
            woi_pkg::DV_DIST:
            begin
                dividend = {8'd0, sum_mag_reg, 23'd0};
                divisor  = {8'd0, tpm_eff};
            end
            woi_pkg::DV_M:
            begin
                dividend = {7'd0, diff_mag_reg, 24'd0};
                divisor  = {8'd0, tpm_eff};
            end
            woi_pkg::DV_THETA:
            begin
                dividend = combine;
                divisor  = {8'd0, sep_eff};
            end
            default:
            begin
                dividend = combine;
                divisor  = {el_reg, 8'd0};
            end
        endcase

        dc_mag    = (dist_mag_reg > 56'h80000000000) ? 44'h80000000000 : dist_mag_reg[43:0];
        theta_s64 = theta_neg_reg ? (64'd0 - {23'd0, theta_mag_reg}) : {23'd0, theta_mag_reg};

        gain_sel = (cmd.msrc == woi_pkg::MS_GAIN);
        case (cmd.msrc)
            woi_pkg::MS_STEP:
            begin
                mul_a64 = theta_s64;
                mul_b   = woi_pkg::RAD_TO_BA;
            end
            woi_pkg::MS_GAIN:
            begin
                mul_a64 = {8'd0, dist_mag_reg};
                mul_b   = woi_pkg::GAIN_Q30;
            end
            woi_pkg::MS_LIN:
            begin
                mul_a64 = {20'd0, dc_mag};
                mul_b   = woi_pkg::MEGA;
            end
            woi_pkg::MS_TURN:
            begin
                mul_a64 = {23'd0, theta_mag_reg};
                mul_b   = woi_pkg::MEGA;
            end
            default:
            begin
                mul_a64 = {20'd0, m_mag_reg};
                mul_b   = woi_pkg::MEGA;
            end
        endcase

        if (cmd.op == woi_pkg::OP_MUL_HI)
        begin
            mul_a = gain_sel ? {6'd0, dist_mag_reg[55:30]} : mul_a64[63:32];
        end
        else
        begin
            mul_a = gain_sel ? {2'd0, dist_mag_reg[29:0]} : mul_a64[31:0];
        end
        prod = {32'd0, mul_a} * {32'd0, mul_b};

        step_sum = combine[47:0] + 48'd32768;

        gain_r = prod_hi_reg + (prod_lo_reg >> 30);
        x_init = dist_neg_reg ? -$signed(gain_r[59:0]) : $signed(gain_r[59:0]);
        ang    = acc_heading_reg - step_reg;
        ang_t  = ang + 32'h40000000;
        ang_f  = ang_t[31] ? (ang ^ 32'h80000000) : ang;
        x_fold = ang_t[31] ? -x_init : x_init;

        xs     = x_reg >>> cmd.idx;
        ys     = y_reg >>> cmd.idx;
        atan_z = {2'd0, woi_pkg::atan_ba(cmd.idx)};

        sum_x = {{13{acc_x_reg[47]}}, acc_x_reg} + {x_reg[59], x_reg};
        sum_y = {{13{acc_y_reg[47]}}, acc_y_reg} + {y_reg[59], y_reg};
        if (sum_x > ACC_MAX)
        begin
            acc_x_next = ACC_MAX[47:0];
        end
        else if (sum_x < ACC_MIN)
        begin
            acc_x_next = ACC_MIN[47:0];
        end
        else
        begin
            acc_x_next = sum_x[47:0];
        end
        if (sum_y > ACC_MAX)
        begin
            acc_y_next = ACC_MAX[47:0];
        end
        else if (sum_y < ACC_MIN)
        begin
            acc_y_next = ACC_MIN[47:0];
        end
        else
        begin
            acc_y_next = sum_y[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg         <= woi_pkg::TPM_RESET;
            sep_reg         <= woi_pkg::SEP_RESET;
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    woi_pkg::REG_TPM: tpm_reg <= cfg_data;
                    woi_pkg::REG_SEP: sep_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == woi_pkg::OP_CAPT)
            begin
                prev_left_reg  <= lu;
                prev_right_reg <= ru;
            end
            if (cmd.op == woi_pkg::OP_ACCUM)
            begin
                acc_x_reg       <= acc_x_next;
                acc_y_reg       <= acc_y_next;
                acc_heading_reg <= acc_heading_reg + step_reg;
            end
            if (cmd.op == woi_pkg::OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            woi_pkg::OP_CAPT:
            begin
                sum_neg_reg  <= sum33[32];
                sum_mag_reg  <= sum33[32] ? (33'd0 - sum33) : sum33;
                diff_neg_reg <= diff33[32];
                diff_mag_reg <= diff33[32] ? (33'd0 - diff33) : diff33;
                el_reg       <= elapsed_us;
            end
            woi_pkg::OP_LOAD_DIST:
            begin
                dist_neg_reg <= sum_neg_reg;
                dist_mag_reg <= div_q[55:0];
            end
            woi_pkg::OP_LOAD_M:
            begin
                m_neg_reg <= diff_neg_reg;
                m_mag_reg <= (div_q > 64'h80000000000) ? 44'h80000000000 : div_q[43:0];
            end
            woi_pkg::OP_LOAD_THETA:
            begin
                theta_neg_reg <= m_neg_reg;
                theta_mag_reg <= (div_q > 64'h10000000000) ? 41'h10000000000 : div_q[40:0];
            end
            woi_pkg::OP_MUL_LO:
            begin
                prod_lo_reg <= prod;
            end
            woi_pkg::OP_MUL_HI:
            begin
                prod_hi_reg <= prod;
            end
            woi_pkg::OP_STEP:
            begin
                step_reg <= step_sum[47:16];
            end
            woi_pkg::OP_CINIT:
            begin
                x_reg <= x_fold;
                y_reg <= '0;
                z_reg <= {{2{ang_f[31]}}, ang_f};
            end
            woi_pkg::OP_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - $signed(atan_z);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + $signed(atan_z);
                end
            end
            woi_pkg::OP_LOAD_LIN:
            begin
                lin_reg <= woi_pkg::sat32(dist_neg_reg, div_q);
            end
            woi_pkg::OP_LOAD_TURN:
            begin
                turn_reg <= woi_pkg::sat32(theta_neg_reg, div_q);
            end
            woi_pkg::OP_ZERO_VEL:
            begin
                lin_reg  <= '0;
                turn_reg <= '0;
            end
            woi_pkg::OP_FINISH:
            begin
                pose_x_reg    <= sat_pose(acc_x_reg);
                pose_y_reg    <= sat_pose(acc_y_reg);
                heading_reg   <= acc_heading_reg[31:16];
                lin_out_reg   <= lin_reg;
                turn_out_reg  <= turn_reg;
                time_zero_reg <= (el_reg == 24'd0);
            end
            default: ;
        endcase
    end

    assign stat.div_done  = div_done;
    assign stat.time_zero = (el_reg == 24'd0);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign pose_x       = pose_x_reg;
    assign pose_y       = pose_y_reg;
    assign heading      = heading_reg;
    assign linear_speed = lin_out_reg;
    assign turn_rate    = turn_out_reg;
    assign time_zero    = time_zero_reg;

endmodule

@@ rtl/wheel_odometry_integrator_unit.sv @@
// Top level of the wheel odometry integrator: controller plus datapath.
// Depends on woi_pkg, woi_ctrl, woi_dpath and woi_div.
// One word at a time, paced by the 2-bit-per-cycle divider that all five divisions
// share (three of them run when elapsed time is zero). The next word is taken once the
// result is registered.
// Reset clears pose, heading, previous counts and sets both registers to defaults.
module wheel_odometry_integrator_unit
#(
    parameter int CORDIC_STEPS = woi_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            left_count,
    input  logic signed [31:0]            right_count,
    input  logic [23:0]                   elapsed_us,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            pose_x,
    output logic signed [31:0]            pose_y,
    output logic [15:0]                   heading,
    output logic signed [31:0]            linear_speed,
    output logic signed [31:0]            turn_rate,
    output logic                          time_zero,
    input  logic                          cfg_we,
    input  logic [woi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [woi_pkg::CFG_W-1:0]     cfg_data
);

    woi_pkg::cmd_t  cmd;
    woi_pkg::stat_t stat;

    woi_ctrl
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    woi_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_count   (left_count),
        .right_count  (right_count),
        .elapsed_us   (elapsed_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .heading      (heading),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .time_zero    (time_zero)
    );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for wheel_odometry_integrator_unit: encoder words in, pose words out.
// Predicts every result with an independent odometry model; depends on woi_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
        logic signed [31:0] lin;
        logic signed [31:0] turn;
        logic               tz;
    } pose_t;

    localparam longint ACC_LIM = 64'sd1 << 47;
    localparam longint LIM43   = 64'sd1 << 43;
    localparam longint LIM40   = 64'sd1 << 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] left_count = '0;
    logic signed [31:0] right_count = '0;
    logic [23:0] elapsed_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] pose_x, pose_y, linear_speed, turn_rate;
    logic [15:0] heading;
    logic time_zero;
    logic cfg_we = 1'b0;
    logic [woi_pkg::CFG_IDX_W-1:0] cfg_index = woi_pkg::REG_TPM;
    logic [woi_pkg::CFG_W-1:0] cfg_data = '0;

    // model state
    logic [23:0] m_tpm, m_sep;
    logic [31:0] m_prev_l, m_prev_r, m_head;
    longint m_ax, m_ay;

    pose_t pose_q[$];
    int errors = 0;
    int n_words = 0;
    int n_results = 0;
    int n_tz = 0;
    bit burst_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wheel_odometry_integrator_unit u_top (.*);

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] sat_word(longint v);
        return 32'(clampl(v, -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic longint scale_gain(longint d);
        logic [63:0] mag, r;
        mag = d < 0 ? 64'(-d) : 64'(d);
        r = (mag >> 30) * 64'(woi_pkg::GAIN_Q30)
            + (((mag & 64'h3FFFFFFF) * 64'(woi_pkg::GAIN_Q30)) >> 30);
        return d < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint arc(int i);
        logic [31:0] t [32] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
            32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
            32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
            32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003,
            32'h00000001, 32'h00000001, 32'h00000000};
        return longint'(t[i]);
    endfunction

    function automatic pose_t odometry_update(logic [31:0] l, logic [31:0] r_raw,
                                              logic [23:0] el);
        pose_t p;
        logic [31:0] ru, ang, step;
        longint tpm, sep, dl, dr, dst, m, th, x, y, z, xs, ys, den, dc;
        ru = 32'd0 - r_raw;
        tpm = m_tpm == 0 ? 1 : longint'(m_tpm);
        sep = m_sep == 0 ? 1 : longint'(m_sep);
        dl = longint'($signed(l - m_prev_l));
        dr = longint'($signed(ru - m_prev_r));
        m_prev_l = l;
        m_prev_r = ru;
        dst = (dl + dr) * 8388608 / tpm;
        m = clampl((dr - dl) * 16777216 / tpm, -LIM43, LIM43);
        th = clampl(m * 1000000 / sep, -LIM40, LIM40);
        step = 32'((th * longint'(woi_pkg::RAD_TO_BA) + 32768) >>> 16);
        ang = m_head - step;
        x = scale_gain(dst);
        y = 0;
        if (((ang + 32'h40000000) & 32'h80000000) != 0)
        begin
            x = -x;
            ang = ang - 32'h80000000;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < woi_pkg::CORDIC_STEPS_DEF; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= arc(i);
            end
            else
            begin
                x += ys; y -= xs; z += arc(i);
            end
        end
        m_ax = clampl(m_ax + x, -ACC_LIM, ACC_LIM - 1);
        m_ay = clampl(m_ay + y, -ACC_LIM, ACC_LIM - 1);
        m_head = m_head + step;
        p.px = sat_word(floor_shift(m_ax, 8));
        p.py = sat_word(floor_shift(m_ay, 8));
        p.hd = m_head[31:16];
        if (el == 0)
        begin
            p.lin = '0; p.turn = '0; p.tz = 1'b1;
        end
        else
        begin
            den = longint'(el) * 256;
            dc = clampl(dst, -LIM43, LIM43);
            p.lin = sat_word(dc * 1000000 / den);
            p.turn = sat_word(th * 1000000 / den);
            p.tz = 1'b0;
        end
        return p;
    endfunction

    task automatic send_word(logic [31:0] l, logic [31:0] r, logic [23:0] el);
        int gap;
        if (!burst_on)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        if ($urandom_range(0, 15) == 0)
            burst_on = !burst_on;
        in_valid <= 1'b1;
        left_count <= l;
        right_count <= r;
        elapsed_us <= el;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pose_q.push_back(odometry_update(l, r, el));
        n_words++;
        if (el == 0)
            n_tz++;
    endtask

    task automatic write_reg(logic [woi_pkg::CFG_IDX_W-1:0] idx,
                             logic [woi_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == woi_pkg::REG_TPM)
            m_tpm = val;
        else
            m_sep = val;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 7) < 3) && (n_words % 200 > 40);
        if (out_valid && !out_stall)
        begin
            n_results++;
            if (pose_q.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                pose_t e;
                e = pose_q.pop_front();
                if (pose_x !== e.px)
                begin
                    $error("pose_x exp %0d got %0d", e.px, pose_x); errors++;
                end
                if (pose_y !== e.py)
                begin
                    $error("pose_y exp %0d got %0d", e.py, pose_y); errors++;
                end
                if (heading !== e.hd)
                begin
                    $error("heading exp %0d got %0d", e.hd, heading); errors++;
                end
                if (linear_speed !== e.lin)
                begin
                    $error("linear_speed exp %0d got %0d", e.lin, linear_speed); errors++;
                end
                if (turn_rate !== e.turn)
                begin
                    $error("turn_rate exp %0d got %0d", e.turn, turn_rate); errors++;
                end
                if (time_zero !== e.tz)
                begin
                    $error("time_zero exp %0d got %0d", e.tz, time_zero); errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rnd_delta(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_directed;
        send_word(32'd1000, -32'sd1000, 24'd10000);
        send_word(32'd1000, -32'sd1000, 24'd0);
        send_word(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF);
        send_word(32'h80000000, 32'h7FFFFFFF, 24'd1);
        send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 24'd1);
        send_word(32'hFFFFFFFF, 32'h00000000, 24'd0);
        send_word(32'd0, 32'd0, 24'd5000);
        send_word(32'd50000, 32'd50000, 24'd100);
        send_word(-32'sd50000, 32'd0, 24'd100);
        send_word(32'h55555555, 32'hAAAAAAAA, 24'h555555);
        send_word(32'hAAAAAAAA, 32'h55555555, 24'hAAAAAA);
    endtask

    task automatic test_register_extremes;
        drain();
        write_reg(woi_pkg::REG_TPM, 24'd0);
        write_reg(woi_pkg::REG_SEP, 24'd0);
        send_word(32'd7, 32'd3, 24'd1);
        send_word(32'h40000000, 32'h40000000, 24'd1);
        drain();
        write_reg(woi_pkg::REG_TPM, 24'd1);
        write_reg(woi_pkg::REG_SEP, 24'hFFFFFF);
        send_word(32'h12345678, 32'h87654321, 24'd3);
        send_word(32'd0, 32'd0, 24'd0);
        drain();
        write_reg(woi_pkg::REG_TPM, 24'hFFFFFF);
        write_reg(woi_pkg::REG_SEP, 24'd1);
        send_word(32'd100000, 32'd0, 24'd200);
        send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_random_drive(int count);
        logic [31:0] l, r;
        int span;
        l = m_prev_l;
        r = 32'd0 - m_prev_r;
        for (int k = 0; k < count; k++)
        begin
            if (k % 250 == 0)
            begin
                drain();
                write_reg(woi_pkg::REG_TPM, k % 500 == 0 ? woi_pkg::TPM_RESET
                          : 24'($urandom_range(1, 24'hFFFFFF)));
                write_reg(woi_pkg::REG_SEP, k % 500 == 0 ? woi_pkg::SEP_RESET
                          : 24'($urandom_range(1, 24'hFFFFFF)));
            end
            case ($urandom_range(0, 9))
                0:       begin l = $urandom; r = $urandom; end
                1, 2:    span = 2000000;
                default: span = 3000;
            endcase
            l = l + rnd_delta(span);
            r = r + rnd_delta(span);
            send_word(l, r, $urandom_range(0, 19) == 0 ? 24'd0 :
                      ($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 20000))));
        end
    endtask

    initial
    begin
        m_tpm = woi_pkg::TPM_RESET;
        m_sep = woi_pkg::SEP_RESET;
        m_prev_l = '0; m_prev_r = '0; m_head = '0;
        m_ax = 0; m_ay = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_drive(1000);
        drain();
        $display("covered %0d words, %0d results, %0d with zero elapsed time",
                 n_words, n_results, n_tz);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
